@@ rtl/core/sorted_sparse_vector_table_assert.svh @@
// Assertion macros shared by the table RTL.
// Each expects i_clk and i_rst_n in scope.
`ifndef SORTED_SPARSE_VECTOR_TABLE_ASSERT_SVH
`define SORTED_SPARSE_VECTOR_TABLE_ASSERT_SVH

// Implication checked at every clock edge outside reset.
`define SSVT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define SSVT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/ssvt_pkg.sv @@
`default_nettype none
package ssvt_pkg;

    localparam int VALUE_W     = 32;
    localparam int IDX_FIELD_W = 16;
    localparam int CMD_W       = 2;

    localparam logic [CMD_W-1:0] CMD_SET = 2'd0;
    localparam logic [CMD_W-1:0] CMD_GET = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ADD = 2'd2;
    localparam logic [CMD_W-1:0] CMD_SUB = 2'd3;

    typedef struct packed {
        logic [VALUE_W-1:0] result_value;
        logic               was_present;
        logic               table_full;
    } t_status;

endpackage
`default_nettype wire

@@ rtl/core/ssvt_cell.sv @@
`default_nettype none
// One table slot of the rotating ring; takes its neighbor's entry on shift.
module ssvt_cell #(
    parameter int KEY_W = 16
) (
    input  logic                        i_clk,
    input  logic                        i_shift,
    input  logic [KEY_W-1:0]            i_idx,
    input  logic [ssvt_pkg::VALUE_W-1:0] i_val,
    output logic [KEY_W-1:0]            o_idx,
    output logic [ssvt_pkg::VALUE_W-1:0] o_val
);
    import ssvt_pkg::*;

    logic [KEY_W-1:0]   r_idx;
    logic [VALUE_W-1:0] r_val;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_idx <= i_idx;
            r_val <= i_val;
        end
    end

    assign o_idx = r_idx;
    assign o_val = r_val;

endmodule
`default_nettype wire

@@ rtl/core/ssvt_merge.sv @@
`default_nettype none
// Merge unit at the head of the ring: sees one slot per cycle in index order,
// passes it on, or splices the new entry in / drops the matched one.
module ssvt_merge #(
    parameter int CAPACITY = 64,
    parameter int KEY_W    = 16,
    parameter int CNT_W    = 6,
    parameter int CW       = 7
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [ssvt_pkg::CMD_W-1:0]   i_cmd,
    input  logic [KEY_W-1:0]             i_key,
    input  logic [ssvt_pkg::VALUE_W-1:0] i_val,
    input  logic [KEY_W-1:0]             i_head_idx,
    input  logic [ssvt_pkg::VALUE_W-1:0] i_head_val,
    input  logic [KEY_W-1:0]             i_next_idx,
    input  logic [ssvt_pkg::VALUE_W-1:0] i_next_val,
    input  logic                         i_ack,
    output logic                         o_shift,
    output logic [KEY_W-1:0]             o_tail_idx,
    output logic [ssvt_pkg::VALUE_W-1:0] o_tail_val,
    output logic                         o_finished,
    output ssvt_pkg::t_status            o_status,
    output logic [CW-1:0]                o_count
);
    import ssvt_pkg::*;

    localparam logic [1:0] MODE_SEARCH = 2'd0;
    localparam logic [1:0] MODE_PASS   = 2'd1;
    localparam logic [1:0] MODE_INSERT = 2'd2;
    localparam logic [1:0] MODE_REMOVE = 2'd3;

    logic               r_busy, n_busy;
    logic               r_finished, n_finished;
    logic [CNT_W-1:0]   r_k, n_k;
    logic [1:0]         r_mode, n_mode;
    logic [CW-1:0]      r_used, n_used;
    logic [CMD_W-1:0]   r_cmd;
    logic [KEY_W-1:0]   r_key;
    logic [VALUE_W-1:0] r_val;
    logic [KEY_W-1:0]   r_carry_idx, n_carry_idx;
    logic [VALUE_W-1:0] r_carry_val, n_carry_val;
    t_status            r_status, n_status;

    logic               w_in_range, w_lt, w_eq, w_last, w_sub, w_full_tbl;
    logic [VALUE_W-1:0] w_base, w_newval;

    assign w_in_range = CW'(r_k) < r_used;
    assign w_lt       = i_head_idx < r_key;
    assign w_eq       = i_head_idx == r_key;
    assign w_last     = r_k == CNT_W'(CAPACITY - 1);
    assign w_sub      = r_cmd == CMD_SUB;
    assign w_full_tbl = r_used == CW'(CAPACITY);
    assign w_base     = (w_in_range && w_eq) ? i_head_val : '0;
    // one adder: subtract as add of the inverted operand plus one
    assign w_newval   = (r_cmd == CMD_SET) ? r_val :
                        w_base + (r_val ^ {VALUE_W{w_sub}}) + VALUE_W'(w_sub);

    always_comb begin
        n_busy      = r_busy;
        n_finished  = r_finished;
        n_k         = r_k;
        n_mode      = r_mode;
        n_used      = r_used;
        n_carry_idx = r_carry_idx;
        n_carry_val = r_carry_val;
        n_status    = r_status;
        o_tail_idx  = i_head_idx;
        o_tail_val  = i_head_val;

        if (i_ack) begin
            n_finished = 1'b0;
        end
        if (i_start) begin
            n_busy   = 1'b1;
            n_k      = '0;
            n_mode   = MODE_SEARCH;
            n_status = '0;
        end

        if (r_busy) begin
            n_k = r_k + CNT_W'(1);
            case (r_mode)
                MODE_SEARCH: begin
                    if (w_in_range && w_lt) begin
                        // still before the key; the full-table miss ends here
                        if (w_last && w_full_tbl && r_cmd != CMD_GET && w_newval != '0) begin
                            n_status.table_full = 1'b1;
                        end
                    end else if (w_in_range && w_eq) begin
                        n_status.was_present = 1'b1;
                        if (r_cmd == CMD_GET) begin
                            n_status.result_value = i_head_val;
                            n_mode = MODE_PASS;
                        end else if (w_newval == '0) begin
                            o_tail_idx = i_next_idx;
                            o_tail_val = i_next_val;
                            n_used     = r_used - CW'(1);
                            n_mode     = MODE_REMOVE;
                        end else begin
                            o_tail_idx = r_key;
                            o_tail_val = w_newval;
                            n_status.result_value = w_newval;
                            n_mode = MODE_PASS;
                        end
                    end else begin
                        // key absent, insertion point reached
                        if (r_cmd == CMD_GET || w_newval == '0) begin
                            n_mode = MODE_PASS;
                        end else if (w_full_tbl) begin
                            n_status.table_full = 1'b1;
                            n_mode = MODE_PASS;
                        end else begin
                            o_tail_idx  = r_key;
                            o_tail_val  = w_newval;
                            n_carry_idx = i_head_idx;
                            n_carry_val = i_head_val;
                            n_used      = r_used + CW'(1);
                            n_status.result_value = w_newval;
                            n_mode = MODE_INSERT;
                        end
                    end
                end
                MODE_INSERT: begin
                    o_tail_idx  = r_carry_idx;
                    o_tail_val  = r_carry_val;
                    n_carry_idx = i_head_idx;
                    n_carry_val = i_head_val;
                end
                MODE_REMOVE: begin
                    o_tail_idx = i_next_idx;
                    o_tail_val = i_next_val;
                end
                default: begin
                end
            endcase
            if (w_last) begin
                n_busy     = 1'b0;
                n_finished = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_finished <= 1'b0;
            r_used     <= '0;
        end else begin
            r_busy     <= n_busy;
            r_finished <= n_finished;
            r_used     <= n_used;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k         <= n_k;
        r_mode      <= n_mode;
        r_carry_idx <= n_carry_idx;
        r_carry_val <= n_carry_val;
        r_status    <= n_status;
        if (i_start) begin
            r_cmd <= i_cmd;
            r_key <= i_key;
            r_val <= i_val;
        end
    end

    assign o_shift    = r_busy;
    assign o_finished = r_finished;
    assign o_status   = r_status;
    assign o_count    = r_used;

`include "sorted_sparse_vector_table_assert.svh"

    `SSVT_ASSERT_IMP(a_used_bound, 1'b1, r_used <= CW'(CAPACITY), "entry count above capacity")
    `SSVT_ASSERT_IMP(a_start_idle, i_start, !r_busy && !r_finished, "start while an item is open")
    `SSVT_ASSERT_IMP(a_full_absent, r_finished && r_status.table_full,
        !r_status.was_present && r_status.result_value == '0, "full flag on a present key")
    `SSVT_ASSERT_NEXT(a_pass_ends, r_busy && w_last, !r_busy && r_finished,
        "ring pass did not close")

endmodule
`default_nettype wire

@@ rtl/core/sorted_sparse_vector_table.sv @@
`default_nettype none
// Sorted sparse vector table: up to CAPACITY nonzero (index, value) entries
// held in ascending index order in a ring of slot cells.
// Input channel (s_axis): tuser carries cmd (set, get, add, subtract), tdata
// carries entry_index and entry_value. Output channel (m_axis): one result
// item per input item with the value after the operation, whether the index
// was present, whether an insert was dropped on a full table, and the entry
// count after the operation.
// Operation: on accept the ring rotates once through all CAPACITY slots, one
// slot per cycle, past the merge unit, which compares each slot with the key
// and splices a new entry in (carry register) or drops the matched one (takes
// the slot behind it). After the full rotation every slot is back in place.
// One item is in work at a time; the next is accepted once the result of
// the last has moved from the merge unit into the output register.
// The output register lets the next item be accepted while a result waits.
// When the receiver stalls, a finished result stays in the merge unit until
// the output register frees, and no new item is accepted meanwhile.
// Reset (synchronous, active low) empties the table; slot contents are not
// cleared, since slots at or beyond the entry count are never used.
module sorted_sparse_vector_table #(
    parameter int CAPACITY   = 64,
    parameter int INDEX_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input item
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,  // [15:0] entry_index, [47:16] entry_value
    input  logic [1:0]  i_s_axis_tuser,  // [1:0] cmd
    // result item
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [31:0] result_value, [32] was_present, [33] table_full,
    // [33+CW:34] entry_count, zero fill above
    output logic [((34 + $clog2(CAPACITY + 1) + 7) / 8) * 8 - 1:0] o_m_axis_tdata
);
    import ssvt_pkg::*;

    localparam int KEY_W  = (INDEX_BITS < IDX_FIELD_W) ? INDEX_BITS : IDX_FIELD_W;
    localparam int CNT_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW     = $clog2(CAPACITY + 1);
    localparam int OUT_W  = ((34 + CW + 7) / 8) * 8;
    localparam int NEXT_I = (CAPACITY > 1) ? 1 : 0;

    logic [KEY_W-1:0]   w_idx [CAPACITY];
    logic [VALUE_W-1:0] w_val [CAPACITY];
    logic [KEY_W-1:0]   w_tail_idx;
    logic [VALUE_W-1:0] w_tail_val;
    logic               w_shift, w_finished, w_ack, w_start;
    t_status            w_status;
    logic [CW-1:0]      w_count;

    logic               r_o_valid;
    t_status            r_out_status;
    logic [CW-1:0]      r_out_count;

    // ring: each slot takes the one behind it; the merge output enters at the tail
    for (genvar g = 0; g < CAPACITY; g++) begin : g_slot
        if (g == CAPACITY - 1) begin : g_tail
            ssvt_cell #(.KEY_W(KEY_W)) u_cell (
                .i_clk  (i_clk),
                .i_shift(w_shift),
                .i_idx  (w_tail_idx),
                .i_val  (w_tail_val),
                .o_idx  (w_idx[g]),
                .o_val  (w_val[g])
            );
        end else begin : g_body
            ssvt_cell #(.KEY_W(KEY_W)) u_cell (
                .i_clk  (i_clk),
                .i_shift(w_shift),
                .i_idx  (w_idx[g + 1]),
                .i_val  (w_val[g + 1]),
                .o_idx  (w_idx[g]),
                .o_val  (w_val[g])
            );
        end
    end

    assign o_s_axis_tready = !w_shift && !w_finished;
    assign w_start         = i_s_axis_tvalid && o_s_axis_tready;
    assign w_ack           = w_finished && (!r_o_valid || i_m_axis_tready);

    ssvt_merge #(
        .CAPACITY(CAPACITY),
        .KEY_W   (KEY_W),
        .CNT_W   (CNT_W),
        .CW      (CW)
    ) u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_cmd      (i_s_axis_tuser),
        .i_key      (i_s_axis_tdata[KEY_W-1:0]),
        .i_val      (i_s_axis_tdata[47:16]),
        .i_head_idx (w_idx[0]),
        .i_head_val (w_val[0]),
        .i_next_idx (w_idx[NEXT_I]),
        .i_next_val (w_val[NEXT_I]),
        .i_ack      (w_ack),
        .o_shift    (w_shift),
        .o_tail_idx (w_tail_idx),
        .o_tail_val (w_tail_val),
        .o_finished (w_finished),
        .o_status   (w_status),
        .o_count    (w_count)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_ack) begin
            r_o_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ack) begin
            r_out_status <= w_status;
            r_out_count  <= w_count;
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = OUT_W'({r_out_count, r_out_status.table_full,
                                     r_out_status.was_present, r_out_status.result_value});

endmodule
`default_nettype wire
